@@ src/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, command and status codes, and the control structs that the
// positional list engine hands to its row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

   // list capacity and derived widths
   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // beat field widths
   localparam int CMD_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 6;
   localparam int COUNT_W  = 7;

   // width that holds any slot, position or count for compares
   localparam int SLOT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_HEAD = 4'd0,
      CMD_INS_TAIL = 4'd1,
      CMD_INS_AT   = 4'd2,
      CMD_INS_ORD  = 4'd3,
      CMD_DEL_HEAD = 4'd4,
      CMD_DEL_TAIL = 4'd5,
      CMD_DEL_AT   = 4'd6,
      CMD_SEARCH   = 4'd7,
      CMD_CLEAR    = 4'd8
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   // what a cell's flag means for the command in flight
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_EQ   = 2'd1,
      KIND_ORD  = 2'd2,
      KIND_SEL  = 2'd3
   } kind_type;

   // how a cell moves its entry on the update cycle
   typedef enum logic [1:0] {
      MODE_HOLD = 2'd0,
      MODE_INS  = 2'd1,
      MODE_DEL  = 2'd2
   } mode_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
      logic [CNT_W-1:0]     count;
      logic [SLOT_W-1:0]    sel;
   } cell_cmp_type;

   typedef struct packed {
      mode_type             mode;
      logic [SLOT_W-1:0]    slot;
      logic [VALUE_W-1:0]   value;
   } cell_upd_type;

endpackage

`default_nettype wire

@@ src/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, raises a match flag on the compare cycle and
// takes its neighbor's entry on the update cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell (
   input  wire logic                         clock,
   input  wire logic [ple_pkg::IDX_W-1:0]    cell_index,
   input  wire logic                         cmp_en,
   input  wire ple_pkg::cell_cmp_type        cmp,
   input  wire ple_pkg::cell_upd_type        upd,
   input  wire logic [ple_pkg::VALUE_W-1:0]  left_entry,
   input  wire logic [ple_pkg::VALUE_W-1:0]  right_entry,
   output logic      [ple_pkg::VALUE_W-1:0]  entry,
   output logic                              flag
);
   import ple_pkg::*;

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               flag_ff, flag_in;
   logic [SLOT_W-1:0]  my_slot;
   logic               live;

   assign my_slot = SLOT_W'(cell_index);
   assign live    = my_slot < SLOT_W'(cmp.count);

   always_comb begin
      case (cmp.kind)
         KIND_EQ:  flag_in = live && (entry_ff == cmp.value);
         KIND_ORD: begin
            // head takes the value in front only when strictly greater
            if (my_slot == '0) begin
               flag_in = live && ($signed(cmp.value) < $signed(entry_ff));
            end else begin
               flag_in = live && !($signed(entry_ff) < $signed(cmp.value));
            end
         end
         KIND_SEL: flag_in = (my_slot == cmp.sel);
         default:  flag_in = 1'b0;
      endcase
   end

   always_comb begin
      unique case (upd.mode)
         MODE_INS: begin
            if (my_slot > upd.slot) begin
               entry_in = left_entry;
            end else if (my_slot == upd.slot) begin
               entry_in = upd.value;
            end else begin
               entry_in = entry_ff;
            end
         end
         MODE_DEL: entry_in = (my_slot >= upd.slot) ? right_entry : entry_ff;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmp_en) begin
         flag_ff <= flag_in;
      end
   end

   assign entry = entry_ff;
   assign flag  = flag_ff;

endmodule

`default_nettype wire

@@ src/ple_locate.sv @@
// ----------------------------------------------------------------------------
// ple_locate
// Finds the lowest raised flag across the cell row: isolates it with a
// two's-complement and, then encodes the one-hot bit to an index.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_locate (
   input  wire logic [ple_pkg::DEPTH-1:0]  flags,
   output logic                            any,
   output logic      [ple_pkg::IDX_W-1:0]  index
);
   import ple_pkg::*;

   logic [DEPTH-1:0] lowest;

   assign lowest = flags & (~flags + DEPTH'(1));
   assign any    = |flags;

   always_comb begin
      index = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

@@ src/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded list of signed 32-bit values kept in a row of shifting cells.
// Commands insert, delete, search or clear; each gives one result beat.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     cmd, value, position
//  rsp      out        rsp_tvalid/tready     status, removed_value,
//                                            found_index, entry_count
//
//  each command has a compare cycle in which every cell latches
//  its match flag, then an update cycle that locates the slot and shifts the
//  cells from that slot on by one cell in either direction; the update cycle
//  waits while the result register holds a beat not yet taken, and it
//  registers the result beat; a new command is taken as soon as the update cycle has written the result
//  register, even while that result is still waiting on rsp_tready
//  reset empties the list at once (entry count cleared, no clearing pass)
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // command beat
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [3:0] cmd, [35:4] value, [42:36] position, [47:43] zero
   input  wire logic [ple_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result beat
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [1:0] status, [33:2] removed_value, [39:34] found_index,
   // [46:40] entry_count, [47] zero
   output logic      [ple_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ple_pkg::*;

   // unpacked command beat
   cmd_type             req_cmd;
   logic [VALUE_W-1:0]  req_value;
   logic [POS_W-1:0]    req_pos;
   logic                req_fire;

   assign req_cmd   = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_value = req_tdata[CMD_W +: VALUE_W];
   assign req_pos   = req_tdata[CMD_W + VALUE_W +: POS_W];

   // command held across the compare and update cycles
   logic                busy_ff, busy_in;
   cmd_type             cmd_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [CNT_W-1:0]    count_ff, count_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic upd_go;

   // no beat is taken while reset is held
   assign req_tready = !busy_ff && !reset;
   assign req_fire   = req_tvalid && req_tready;
   // update cycle runs once the result register is free or draining
   assign upd_go     = busy_ff && (!rsp_valid_ff || rsp_tready);

   // compare-cycle broadcast to the cells
   cell_cmp_type cmp;

   always_comb begin
      cmp.value = req_value;
      cmp.count = count_ff;
      cmp.kind  = KIND_NONE;
      cmp.sel   = '0;
      unique case (req_cmd)
         CMD_SEARCH:   cmp.kind = KIND_EQ;
         CMD_INS_ORD:  cmp.kind = KIND_ORD;
         CMD_DEL_HEAD: cmp.kind = KIND_SEL;
         CMD_DEL_TAIL: begin
            // wraps on an empty list so that no cell is picked
            cmp.kind = KIND_SEL;
            cmp.sel  = SLOT_W'(count_ff) - SLOT_W'(1);
         end
         CMD_DEL_AT: begin
            cmp.kind = KIND_SEL;
            cmp.sel  = SLOT_W'(req_pos);
         end
         default: cmp.kind = KIND_NONE;
      endcase
   end

   // cell row
   cell_upd_type        upd;
   logic [VALUE_W-1:0]  ent [DEPTH];
   logic [DEPTH-1:0]    flags;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] left_entry, right_entry;

      if (i == 0) begin : g_head
         assign left_entry = upd.value;
      end else begin : g_mid_l
         assign left_entry = ent[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = ent[i];
      end else begin : g_mid_r
         assign right_entry = ent[i+1];
      end

      ple_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .cmp_en      (req_fire),
         .cmp         (cmp),
         .upd         (upd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (ent[i]),
         .flag        (flags[i])
      );
   end

   // first raised flag in the row
   logic             hit_any;
   logic [IDX_W-1:0] hit_idx;

   ple_locate u_locate (
      .flags (flags),
      .any   (hit_any),
      .index (hit_idx)
   );

   // entry picked by a delete: flags are one-hot on the selected cell
   logic [VALUE_W-1:0] picked;

   always_comb begin
      picked = '0;
      for (int i = 0; i < DEPTH; i++) begin
         picked = picked | (ent[i] & {VALUE_W{flags[i]}});
      end
   end

   // update-cycle decode
   logic [SLOT_W-1:0]   slot;
   logic [SLOT_W-1:0]   count_w;
   status_type          status;
   mode_type            mode;
   logic [VALUE_W-1:0]  removed;
   logic [FOUND_W-1:0]  found;
   logic [CNT_W-1:0]    count_next;

   assign count_w = SLOT_W'(count_ff);

   always_comb begin
      slot = '0;
      unique case (cmd_ff)
         CMD_INS_TAIL: slot = count_w;
         CMD_INS_AT:   slot = SLOT_W'(pos_ff);
         CMD_INS_ORD:  slot = hit_any ? SLOT_W'(hit_idx) : count_w;
         CMD_DEL_TAIL: slot = count_w - SLOT_W'(1);
         CMD_DEL_AT:   slot = SLOT_W'(pos_ff);
         default:      slot = '0;
      endcase
   end

   always_comb begin
      status     = ST_OK;
      mode       = MODE_HOLD;
      removed    = '0;
      found      = '0;
      count_next = count_ff;
      unique case (cmd_ff) inside
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT, CMD_INS_ORD: begin
            // bad position is checked ahead of a full list
            if (slot > count_w) begin
               status = ST_BAD;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               status = ST_FULL;
            end else begin
               mode       = MODE_INS;
               count_next = count_ff + CNT_W'(1);
            end
         end
         CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
            if (slot >= count_w) begin
               status = ST_BAD;
            end else begin
               mode       = MODE_DEL;
               removed    = picked;
               count_next = count_ff - CNT_W'(1);
            end
         end
         CMD_SEARCH: begin
            if (hit_any) begin
               found = FOUND_W'(hit_idx);
            end else begin
               status = ST_MISS;
            end
         end
         CMD_CLEAR: count_next = '0;
         default:   status = ST_OK;
      endcase
   end

   assign upd.mode  = upd_go ? mode : MODE_HOLD;
   assign upd.slot  = slot;
   assign upd.value = value_ff;

   // control registers
   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
      if (upd_go) begin
         busy_in      = 1'b0;
         count_in     = count_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, COUNT_W'(count_next), found, removed, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         pos_ff   <= req_pos;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the list never grows past its capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // the count moves by at most one per command, or drops to zero on clear
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff))
         || (count_ff == $past(count_ff) + CNT_W'(1))
         || (count_ff + CNT_W'(1) == $past(count_ff))
         || (count_ff == '0))
      else $error("entry count jumped");

   // a delete picks at most one cell
   a_sel_onehot : assert property (@(posedge clock) disable iff (reset)
      busy_ff && (cmd_ff == CMD_DEL_HEAD || cmd_ff == CMD_DEL_TAIL
         || cmd_ff == CMD_DEL_AT) |-> $onehot0(flags))
      else $error("delete selected several cells");

   // a full status is only reported with the list at capacity
   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[STATUS_W-1:0] == ST_FULL)
         |-> (count_ff == CNT_W'(DEPTH)))
      else $error("full status with room left");

   // cells never shift while no command is in the update cycle
   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (upd.mode == MODE_HOLD))
      else $error("cell row moved while idle");

endmodule

`default_nettype wire
